@@ rtl/core/bffa_pkg.sv @@
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared sizes, status codes, sequencer states and the bitmap memory request
// for the bitmap first-fit page allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int PAGE_COUNT    = 32768;
  localparam int PAGE_SHIFT    = 12;
  localparam int MAP_WORD_BITS = 64;

  localparam int MAP_DEPTH  = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAP_ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int MAP_CNT_W  = $clog2(MAP_DEPTH + 1);
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);
  localparam int PAGE_IDX_W = $clog2(MAP_DEPTH * MAP_WORD_BITS);

  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_COUNT = (MAP_WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CHUNK_W     = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int PAD_BITS    = CHUNK_COUNT * CHUNK_BITS;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_NO_MEMORY = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_ALLOC,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_WR
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [MAP_ADDR_W-1:0]    waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic                     re;
    logic [MAP_ADDR_W-1:0]    raddr;
  } ram_req_t;

endpackage

@@ rtl/core/bffa_ram.sv @@
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bffa_addr_unit.sv @@
// ----------------------------------------------------------------------------
// bffa_addr_unit
// Shared 64-bit add/subtract unit: page address on allocate, offset from
// base with borrow on free.
// ----------------------------------------------------------------------------
module bffa_addr_unit (
  input  logic        sub,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] sum,
  output logic        borrow
);

  logic [64:0] full;

  assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + 65'(sub);
  assign sum    = full[63:0];
  assign borrow = sub & ~full[64];

endmodule

@@ rtl/core/bffa_seq.sv @@
// ----------------------------------------------------------------------------
// bffa_seq
// Sequencer: bitmap clearing pass, word scan, chunk search, free range check
// and read-modify-write of the bitmap word.
// ----------------------------------------------------------------------------
module bffa_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 operation,
  input  logic [63:0]          page_address,
  input  logic                 cfg_wen,
  input  logic [63:0]          cfg_wdata,
  output logic                 busy,
  output logic                 done,
  output logic [63:0]          result_address,
  output logic [1:0]           status,
  output bffa_pkg::ram_req_t   ram_req,
  input  logic [bffa_pkg::MAP_WORD_BITS-1:0] ram_rdata
);
  import bffa_pkg::*;

  state_t                   state, state_next;
  logic [63:0]              base;
  logic [63:0]              op_addr, op_addr_next;
  logic [MAP_ADDR_W-1:0]    clr_addr, clr_addr_next;
  logic [MAP_CNT_W-1:0]     scan_cnt, scan_cnt_next;
  logic                     pend, pend_next;
  logic [MAP_ADDR_W-1:0]    pend_addr, pend_addr_next;
  logic [MAP_WORD_BITS-1:0] word, word_next;
  logic [MAP_ADDR_W-1:0]    word_addr, word_addr_next;
  logic [CHUNK_W-1:0]       chunk_idx, chunk_idx_next;
  logic [BIT_W-1:0]         bit_pos, bit_pos_next;
  logic [PAGE_IDX_W-1:0]    page_idx, page_idx_next;
  logic                     done_next;
  logic [63:0]              result_address_next;
  logic [1:0]               status_next;

  logic                     au_sub;
  logic [63:0]              au_a, au_b, au_sum;
  logic                     au_borrow;
  logic [PAD_BITS-1:0]      word_pad;
  logic [CHUNK_BITS-1:0]    chunk;
  logic [CHUNK_W+2:0]       bit_full;
  logic                     accept;

  function automatic logic [2:0] ffz8(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!c[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  bffa_addr_unit u_addr (
    .sub    (au_sub),
    .a      (au_a),
    .b      (au_b),
    .sum    (au_sum),
    .borrow (au_borrow)
  );

  assign accept   = start & ~busy;
  assign word_pad = ~(PAD_BITS'(~word));
  assign chunk    = word_pad[{chunk_idx, 3'b000} +: CHUNK_BITS];
  assign bit_full = {chunk_idx, ffz8(chunk)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      base     <= '0;
      clr_addr <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend     <= pend_next;
      done     <= done_next;
      if (cfg_wen) begin
        base <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_addr        <= op_addr_next;
    scan_cnt       <= scan_cnt_next;
    pend_addr      <= pend_addr_next;
    word           <= word_next;
    word_addr      <= word_addr_next;
    chunk_idx      <= chunk_idx_next;
    bit_pos        <= bit_pos_next;
    page_idx       <= page_idx_next;
    result_address <= result_address_next;
    status         <= status_next;
  end

  always_comb begin
    state_next          = state;
    op_addr_next        = op_addr;
    clr_addr_next       = clr_addr;
    scan_cnt_next       = scan_cnt;
    pend_next           = 1'b0;
    pend_addr_next      = pend_addr;
    word_next           = word;
    word_addr_next      = word_addr;
    chunk_idx_next      = chunk_idx;
    bit_pos_next        = bit_pos;
    page_idx_next       = page_idx;
    done_next           = 1'b0;
    result_address_next = result_address;
    status_next         = status;
    busy                = 1'b1;
    ram_req             = '0;
    au_sub              = 1'b0;
    au_a                = base;
    au_b                = 64'(page_idx) << PAGE_SHIFT;

    unique case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          op_addr_next  = page_address;
          scan_cnt_next = '0;
          state_next    = operation ? S_FREE_CHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt != MAP_CNT_W'(MAP_DEPTH)) begin
          ram_req.re     = 1'b1;
          ram_req.raddr  = scan_cnt[MAP_ADDR_W-1:0];
          scan_cnt_next  = scan_cnt + 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = scan_cnt[MAP_ADDR_W-1:0];
        end
        if (pend) begin
          if (ram_rdata != '1) begin
            word_next      = ram_rdata;
            word_addr_next = pend_addr;
            chunk_idx_next = '0;
            pend_next      = 1'b0;
            state_next     = S_FIND;
          end else if (pend_addr == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
            done_next           = 1'b1;
            result_address_next = '0;
            status_next         = STAT_NO_MEMORY;
            state_next          = S_IDLE;
          end
        end
      end
      S_FIND: begin
        if (chunk != '1) begin
          bit_pos_next  = BIT_W'(bit_full);
          page_idx_next = PAGE_IDX_W'(word_addr) * PAGE_IDX_W'(MAP_WORD_BITS)
                          + PAGE_IDX_W'(bit_full);
          state_next    = S_ALLOC;
        end else begin
          chunk_idx_next = chunk_idx + 1'b1;
        end
      end
      S_ALLOC: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if ({1'b0, page_idx} >= (PAGE_IDX_W + 1)'(PAGE_COUNT)) begin
          result_address_next = '0;
          status_next         = STAT_NO_MEMORY;
        end else begin
          ram_req.we          = 1'b1;
          ram_req.waddr       = word_addr;
          ram_req.wdata       = word | (MAP_WORD_BITS'(1) << bit_pos);
          result_address_next = au_sum;
          status_next         = STAT_ALLOCATED;
        end
      end
      S_FREE_CHK: begin
        au_sub = 1'b1;
        au_a   = op_addr;
        au_b   = base;
        if (au_borrow ||
            (au_sum[63:PAGE_SHIFT] >= (64 - PAGE_SHIFT)'(PAGE_COUNT))) begin
          done_next           = 1'b1;
          result_address_next = '0;
          status_next         = STAT_RANGE;
          state_next          = S_IDLE;
        end else begin
          word_addr_next = au_sum[PAGE_SHIFT + BIT_W +: MAP_ADDR_W];
          bit_pos_next   = au_sum[PAGE_SHIFT +: BIT_W];
          state_next     = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = word_addr;
        state_next    = S_FREE_WR;
      end
      S_FREE_WR: begin
        ram_req.we          = 1'b1;
        ram_req.waddr       = word_addr;
        ram_req.wdata       = ram_rdata & ~(MAP_WORD_BITS'(1) << bit_pos);
        done_next           = 1'b1;
        result_address_next = '0;
        status_next         = STAT_FREED;
        state_next          = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_req.we) else $error("bitmap written while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted beat did not raise busy");

  a_addr_alloc_only: assert property (@(posedge clk) disable iff (rst)
    (done && (result_address != '0)) |-> (status == STAT_ALLOCATED))
    else $error("nonzero address with non-allocate status");
`endif

endmodule

@@ rtl/core/bitmap_first_fit_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator_unit
// Allocate: first free page from a used/free bitmap scanned one word a cycle.
// Free: clear the bit of the page holding the given address.
// Allocate scans for the first non-full word, then searches it chunk by chunk
// and writes the page bit back; with no free page it reports no memory.
// Free: range check, then, when in range, bitmap read and write back.
// One beat at a time; busy high meanwhile.
// Reset: clears all MAP_DEPTH (512) words with busy high; base resets to 0.
// ----------------------------------------------------------------------------
module bitmap_first_fit_page_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] page_address,
  input  logic        cfg_wen,
  input  logic [63:0] cfg_wdata,
  output logic        done,
  output logic [63:0] result_address,
  output logic [1:0]  status
);
  import bffa_pkg::*;

  ram_req_t                 ram_req;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  bffa_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .page_address   (page_address),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .busy           (busy),
    .done           (done),
    .result_address (result_address),
    .status         (status),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  bffa_ram #(
    .WIDTH  (MAP_WORD_BITS),
    .DEPTH  (MAP_DEPTH),
    .ADDR_W (MAP_ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ sim/bitmap_first_fit_page_allocator_unit_test.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_fit_page_allocator_unit_test
// Drives allocate and free commands into the page allocator under several
// base addresses and tracks the used/free bitmap in a predictor of its own.
// Each done beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_first_fit_page_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct {
    op_t         op;
    logic [63:0] address;
  } page_cmd_t;

  typedef struct {
    logic [63:0] address;
    status_t     status;
  } page_outcome_t;

  localparam int          CYCLE_LIMIT = 2000000;
  localparam logic [63:0] AREA_BYTES  = 64'(PAGE_COUNT) << PAGE_SHIFT;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_ALLOC;
  logic [63:0] page_address = '0;
  logic        cfg_wen = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        done;
  logic [63:0] result_address;
  logic [1:0]  status;

  bit [MAP_WORD_BITS-1:0] used_map [MAP_DEPTH];
  logic [63:0]            base_model = '0;

  page_cmd_t     pending_q [$];
  page_outcome_t outcome_q [$];

  int unsigned cycle_cnt = 0;
  int          mismatch_cnt = 0;
  int          gap_cnt = 0;
  int          burst_cnt = 0;
  bit          steady = 1'b0;
  int          page_span = 0;

  bitmap_first_fit_page_allocator_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .page_address   (page_address),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .result_address (result_address),
    .status         (status)
  );

  always #1 clk = ~clk;

  function automatic page_outcome_t apply_page_op(op_t op, logic [63:0] addr);
    page_outcome_t res;
    logic [63:0]   idx;
    bit            found;
    int            w;
    int            b;
    res.address = '0;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      res.status = STAT_NO_MEMORY;
      for (w = 0; w < MAP_DEPTH; w++) begin
        if (!found && !(&used_map[w])) begin
          for (b = 0; b < MAP_WORD_BITS; b++) begin
            if (!found && !used_map[w][b] && (w * MAP_WORD_BITS + b) < PAGE_COUNT) begin
              found = 1'b1;
              used_map[w][b] = 1'b1;
              res.address = base_model + (64'(w * MAP_WORD_BITS + b) << PAGE_SHIFT);
              res.status = STAT_ALLOCATED;
            end
          end
        end
      end
    end else if (addr < base_model) begin
      res.status = STAT_RANGE;
    end else begin
      idx = (addr - base_model) >> PAGE_SHIFT;
      if (idx >= 64'(PAGE_COUNT)) begin
        res.status = STAT_RANGE;
      end else begin
        used_map[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS] = 1'b0;
        res.status = STAT_FREED;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 100)
      $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic push_cmd(input op_t op, input logic [63:0] addr);
    page_cmd_t cmd;
    cmd.op = op;
    cmd.address = addr;
    pending_q.push_back(cmd);
    if (op == OP_ALLOC && page_span < PAGE_COUNT)
      page_span++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || outcome_q.size() != 0 || start || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [63:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    base_model = value;
  endtask

  task automatic queue_random_phase(input int count, input int alloc_pct);
    int          r;
    int          idx;
    logic [63:0] offset;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        push_cmd(OP_ALLOC, '0);
      end else if (r < 92) begin
        idx = $urandom_range(0, page_span + 4);
        if (idx >= PAGE_COUNT)
          idx = PAGE_COUNT - 1;
        offset = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : '0;
        push_cmd(OP_FREE, base_model + (64'(idx) << PAGE_SHIFT) + offset);
      end else begin
        case ($urandom_range(0, 4))
          0: push_cmd(OP_FREE, rand64());
          1: push_cmd(OP_FREE, base_model - 64'd1 - 64'($urandom_range(0, 65535)));
          2: push_cmd(OP_FREE, base_model + AREA_BYTES + 64'($urandom));
          3: push_cmd(OP_FREE, base_model + AREA_BYTES - 64'd1 - 64'($urandom_range(0, 4095)));
          default: push_cmd(OP_FREE, base_model +
                            (64'($urandom_range(0, PAGE_COUNT - 1)) << PAGE_SHIFT));
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_cnt = 0;
      burst_cnt = 0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(apply_page_op(op_t'(operation), page_address));
        void'(pending_q.pop_front());
        if (burst_cnt > 0)
          burst_cnt--;
        if (burst_cnt == 0) begin
          burst_cnt = $urandom_range(1, 10);
          if (steady)
            gap_cnt = 0;
          else if ($urandom_range(0, 3) == 0)
            gap_cnt = $urandom_range(8, 40);
          else
            gap_cnt = $urandom_range(0, 4);
        end
      end
      if (gap_cnt > 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        start <= 1'b1;
        operation <= pending_q[0].op;
        page_address <= pending_q[0].address;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    page_outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat addr %h status %0d",
                                  result_address, status));
      end else begin
        want = outcome_q.pop_front();
        if (result_address !== want.address)
          report_mismatch($sformatf("result_address %h, want %h",
                                    result_address, want.address));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bitmap_first_fit_page_allocator_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] next_base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    write_base('0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_FREE, 64'h1ABC);
    push_cmd(OP_FREE, 64'h1000);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_FREE, ALL_ONES);
    push_cmd(OP_FREE, AREA_BYTES);
    push_cmd(OP_FREE, AREA_BYTES - 64'd1);
    push_cmd(OP_FREE, '0);
    push_cmd(OP_ALLOC, '0);

    write_base(64'hFFFF_FFFF_FFFF_D000);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_FREE, '0);
    push_cmd(OP_FREE, 64'hFFFF_FFFF_FFFF_CFFF);
    push_cmd(OP_FREE, ALL_ONES);
    push_cmd(OP_ALLOC, '0);

    write_base(ALL_ONES);
    push_cmd(OP_FREE, ALL_ONES);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_FREE, 64'hFFFF_FFFF_FFFF_FFFE);
    push_cmd(OP_FREE, '0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: next_base = rand64();
        1: next_base = '0;
        2: next_base = 64'($urandom);
        3: next_base = ALL_ONES;
        4: next_base = '0 - (64'($urandom_range(1, 64)) << PAGE_SHIFT);
        default: next_base = rand64() & ~64'hFFF;
      endcase
      write_base(next_base);
      steady = (phase == 1 || phase == 4) ? 1'b1 : 1'b0;
      queue_random_phase(190, (phase == 2) ? 85 : 50);
    end

    wait_idle();
    repeat (600) @(posedge clk);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("bitmap_first_fit_page_allocator_unit test passed");
    end else begin
      $display("bitmap_first_fit_page_allocator_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bffa_pkg.sv
rtl/core/bffa_ram.sv
rtl/core/bffa_addr_unit.sv
rtl/core/bffa_seq.sv
rtl/core/bitmap_first_fit_page_allocator_unit.sv
sim/bitmap_first_fit_page_allocator_unit_test.sv
